// File: rtl/datagram_varint_validator_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion helpers for the datagram varint validator.
// Every macro samples on clock and is held off while reset is high.
// ----------------------------------------------------------------------------
`ifndef DATAGRAM_VARINT_VALIDATOR_TOP_MACROS_SVH
`define DATAGRAM_VARINT_VALIDATOR_TOP_MACROS_SVH

// Same-cycle implication.
`define DVV_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define DVV_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/dvv_pkg.sv
// ----------------------------------------------------------------------------
// dvv_pkg
// Shared types and constants of the datagram varint validator: parse phases,
// status codes, register indexes, the register set and the result record.
// ----------------------------------------------------------------------------
`default_nettype none

package dvv_pkg;

   localparam int REQ_DATA_W = 8;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam int SEQ_W      = 62;
   localparam int RES_W      = 105;
   localparam int RSP_DATA_W = 112;

   typedef enum logic [1:0] {
      PH_HEADER,
      PH_MSGLEN,
      PH_PAYLOAD,
      PH_TRAIL
   } phase_type;

   typedef enum logic [1:0] {
      FLD_VERSION,
      FLD_TYPE,
      FLD_SEQUENCE,
      FLD_COUNT
   } field_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_MALFORMED = 3'd1,
      ST_VERSION   = 3'd2,
      ST_TYPE      = 3'd3,
      ST_LIMIT     = 3'd4
   } status_type;

   localparam logic [CSR_IDX_W-1:0] REG_EXPECTED_VERSION   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MESSAGES_TYPE_CODE = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_DATAGRAM_BYTES = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_MESSAGES       = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_MESSAGE_BYTES  = 3'd4;

   typedef struct packed {
      logic [13:0] expected_version;
      logic [13:0] messages_type_code;
      logic [15:0] max_datagram_bytes;
      logic [7:0]  max_messages;
      logic [15:0] max_message_bytes;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      expected_version:   14'd1,
      messages_type_code: 14'd0,
      max_datagram_bytes: 16'd1400,
      max_messages:       8'd64,
      max_message_bytes:  16'd1024
   };

   // Packed high to low, so status lands in the lowest bits of tdata.
   typedef struct packed {
      logic [15:0]      datagram_length;
      logic [15:0]      messages_offset;
      logic [7:0]       message_count;
      logic [SEQ_W-1:0] sequence_number;
      status_type       status;
   } result_type;

endpackage

`default_nettype wire

// File: rtl/dvv_parser.sv
// ----------------------------------------------------------------------------
// dvv_parser
// Byte-at-a-time varint header and message walker. Updates the datagram
// context on every accepted request and emits one result on the last byte.
// ----------------------------------------------------------------------------
`default_nettype none

module dvv_parser
   import dvv_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  take,
   input  wire logic [7:0]            data_byte,
   input  wire logic                  last_byte,
   input  wire cfg_type               cfg,
   output      logic                  res_valid,
   output      result_type            res
);

   typedef struct packed {
      phase_type        phase;
      field_type        field;
      logic [SEQ_W-1:0] acc;
      logic [2:0]       left;
      logic [13:0]      held_version;
      logic [13:0]      held_type;
      logic [SEQ_W-1:0] held_seq;
      logic [7:0]       held_count;
      logic [7:0]       msgs_left;
      logic [15:0]      payload_left;
      logic [15:0]      byte_cnt;
      logic [15:0]      start_msgs;
      status_type       first_error;
      logic             cnt_over;
      logic             varint_active;
      logic             version_wide;
      logic             type_wide;
   } ctx_type;

   ctx_type          ctx_ff;
   ctx_type          ctx_in;
   logic [SEQ_W-1:0] acc_v;
   logic [2:0]       left_v;
   logic [15:0]      pay_v;
   logic [7:0]       msgs_v;
   status_type       fin_err;
   status_type       fin_status;
   logic             is_ok;

   always_comb begin
      ctx_in     = ctx_ff;
      acc_v      = ctx_ff.acc;
      left_v     = ctx_ff.left;
      pay_v      = ctx_ff.payload_left;
      msgs_v     = ctx_ff.msgs_left;
      fin_err    = ST_OK;
      fin_status = ST_OK;
      is_ok      = 1'b0;
      res_valid  = 1'b0;
      res        = '0;

      if (take) begin
         // saturate the byte count and remember that it ran past the top
         if (ctx_ff.byte_cnt == 16'hFFFF) begin
            ctx_in.cnt_over = 1'b1;
         end else begin
            ctx_in.byte_cnt = ctx_ff.byte_cnt + 16'd1;
         end

         if (ctx_ff.first_error == ST_OK) begin
            case (ctx_ff.phase)
               PH_HEADER, PH_MSGLEN: begin
                  if (!ctx_ff.varint_active) begin
                     acc_v  = {{(SEQ_W-6){1'b0}}, data_byte[5:0]};
                     left_v = 3'((4'd1 << data_byte[7:6]) - 4'd1);
                  end else begin
                     acc_v  = {ctx_ff.acc[SEQ_W-9:0], data_byte};
                     left_v = ctx_ff.left - 3'd1;
                  end
                  ctx_in.acc           = acc_v;
                  ctx_in.left          = left_v;
                  ctx_in.varint_active = 1'b1;

                  if (left_v == 3'd0) begin
                     ctx_in.varint_active = 1'b0;
                     if (ctx_ff.phase == PH_HEADER) begin
                        case (ctx_ff.field)
                           FLD_VERSION: begin
                              ctx_in.held_version = acc_v[13:0];
                              ctx_in.version_wide = |acc_v[SEQ_W-1:14];
                              ctx_in.field        = FLD_TYPE;
                           end
                           FLD_TYPE: begin
                              ctx_in.held_type = acc_v[13:0];
                              ctx_in.type_wide = |acc_v[SEQ_W-1:14];
                              ctx_in.field     = FLD_SEQUENCE;
                           end
                           FLD_SEQUENCE: begin
                              ctx_in.held_seq = acc_v;
                              ctx_in.field    = FLD_COUNT;
                           end
                           default: begin
                              ctx_in.held_count = acc_v[7:0];
                              if (ctx_ff.version_wide ||
                                  ctx_ff.held_version != cfg.expected_version) begin
                                 ctx_in.first_error = ST_VERSION;
                              end else if (ctx_ff.type_wide ||
                                  ctx_ff.held_type != cfg.messages_type_code) begin
                                 ctx_in.first_error = ST_TYPE;
                              end else if (acc_v == '0 || (|acc_v[SEQ_W-1:8]) ||
                                  acc_v[7:0] > cfg.max_messages) begin
                                 ctx_in.first_error = ST_LIMIT;
                              end else begin
                                 ctx_in.msgs_left  = acc_v[7:0];
                                 ctx_in.start_msgs = ctx_in.byte_cnt;
                                 ctx_in.phase      = PH_MSGLEN;
                              end
                           end
                        endcase
                     end else begin
                        if (acc_v == '0 || (|acc_v[SEQ_W-1:16]) ||
                            acc_v[15:0] > cfg.max_message_bytes) begin
                           ctx_in.first_error = ST_LIMIT;
                        end else begin
                           ctx_in.payload_left = acc_v[15:0];
                           ctx_in.phase        = PH_PAYLOAD;
                        end
                     end
                  end
               end
               PH_PAYLOAD: begin
                  pay_v               = ctx_ff.payload_left - 16'd1;
                  ctx_in.payload_left = pay_v;
                  if (pay_v == 16'd0) begin
                     msgs_v           = ctx_ff.msgs_left - 8'd1;
                     ctx_in.msgs_left = msgs_v;
                     ctx_in.phase     = (msgs_v == 8'd0) ? PH_TRAIL : PH_MSGLEN;
                  end
               end
               default: begin
                  // a byte after the last payload
                  ctx_in.first_error = ST_MALFORMED;
               end
            endcase
         end

         if (last_byte) begin
            fin_err = ctx_in.first_error;
            if (fin_err == ST_OK && ctx_in.phase != PH_TRAIL) begin
               fin_err = ST_MALFORMED;
            end
            if (ctx_in.cnt_over || ctx_in.byte_cnt > cfg.max_datagram_bytes) begin
               fin_status = ST_LIMIT;
            end else begin
               fin_status = fin_err;
            end
            is_ok                = (fin_status == ST_OK);
            res_valid            = 1'b1;
            res.status           = fin_status;
            res.sequence_number  = is_ok ? ctx_in.held_seq : '0;
            res.message_count    = is_ok ? ctx_in.held_count : 8'd0;
            res.messages_offset  = is_ok ? ctx_in.start_msgs : 16'd0;
            res.datagram_length  = ctx_in.byte_cnt;
            ctx_in               = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctx_ff <= '0;
      end else begin
         ctx_ff <= ctx_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/dvv_rsp_queue.sv
// ----------------------------------------------------------------------------
// dvv_rsp_queue
// Output register with one skid slot. Keeps the request side open while a
// finished result waits on the response side.
// ----------------------------------------------------------------------------
`default_nettype none

module dvv_rsp_queue
   import dvv_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       push,
   input  wire result_type push_data,
   output      logic       can_push,
   output      logic       out_valid,
   input  wire logic       out_ready,
   output      result_type out_data
);

   logic       head_valid_ff;
   logic       head_valid_in;
   logic       spare_valid_ff;
   logic       spare_valid_in;
   result_type head_ff;
   result_type head_in;
   result_type spare_ff;
   result_type spare_in;
   logic       pop;

   assign pop       = head_valid_ff && out_ready;
   assign can_push  = !spare_valid_ff;
   assign out_valid = head_valid_ff;
   assign out_data  = head_ff;

   always_comb begin
      head_valid_in  = head_valid_ff;
      spare_valid_in = spare_valid_ff;
      head_in        = head_ff;
      spare_in       = spare_ff;
      if (pop) begin
         if (spare_valid_ff) begin
            // advance the skid slot; no push can arrive while it is full
            head_in        = spare_ff;
            spare_valid_in = 1'b0;
         end else if (push) begin
            head_in = push_data;
         end else begin
            head_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!head_valid_ff) begin
            head_in       = push_data;
            head_valid_in = 1'b1;
         end else begin
            spare_in       = push_data;
            spare_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_valid_ff  <= 1'b0;
         spare_valid_ff <= 1'b0;
      end else begin
         head_valid_ff  <= head_valid_in;
         spare_valid_ff <= spare_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff  <= head_in;
      spare_ff <= spare_in;
   end

endmodule

`default_nettype wire

// File: rtl/datagram_varint_validator_top.sv
// A result is registered in the output register, or in its skid slot when
// that register is full. One byte per cycle while req_tready is high.
// The request side stalls only when both the output register and its skid
// slot hold results not yet taken.
// Reset is synchronous: it clears the parse context and the output slots and
// loads the register defaults (version 1, type 0, 1400, 64, 1024).
// ----------------------------------------------------------------------------
// datagram_varint_validator_top
// Streams a datagram in byte by byte, checks its varint header and message
// framing, and reports one status record per datagram.
// ----------------------------------------------------------------------------
`default_nettype none

module datagram_varint_validator_top
   import dvv_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output      logic                  req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,   // [7:0] data_byte
   input  wire logic                  req_tlast,   // last_byte
   output      logic                  rsp_tvalid,
   input  wire logic                  rsp_tready,
   // [2:0] status, [64:3] sequence_number, [72:65] message_count,
   // [88:73] messages_offset, [104:89] datagram_length, rest zero
   output      logic [RSP_DATA_W-1:0] rsp_tdata,
   input  wire logic                  csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

`include "datagram_varint_validator_top_macros.svh"

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic       req_take;
   logic       res_valid;
   result_type res;
   result_type out_res;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            REG_EXPECTED_VERSION:   cfg_in.expected_version   = csr_wdata[13:0];
            REG_MESSAGES_TYPE_CODE: cfg_in.messages_type_code = csr_wdata[13:0];
            REG_MAX_DATAGRAM_BYTES: cfg_in.max_datagram_bytes = csr_wdata[15:0];
            REG_MAX_MESSAGES:       cfg_in.max_messages       = csr_wdata[7:0];
            REG_MAX_MESSAGE_BYTES:  cfg_in.max_message_bytes  = csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_take = req_tvalid && req_tready;

   dvv_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .take      (req_take),
      .data_byte (req_tdata),
      .last_byte (req_tlast),
      .cfg       (cfg_ff),
      .res_valid (res_valid),
      .res       (res)
   );

   dvv_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (res_valid),
      .push_data (res),
      .can_push  (req_tready),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (out_res)
   );

   assign rsp_tdata = {{(RSP_DATA_W-RES_W){1'b0}}, out_res};

   `DVV_ASSERT_NEXT(a_last_gives_rsp, req_take && req_tlast, rsp_tvalid,
      "last byte accepted but no response pending")
   `DVV_ASSERT_NOW(a_error_fields_zero, rsp_tvalid && out_res.status != ST_OK,
      out_res.sequence_number == '0 && out_res.message_count == 8'd0 &&
      out_res.messages_offset == 16'd0, "error response carries header fields")
   `DVV_ASSERT_NOW(a_ok_has_messages, rsp_tvalid && out_res.status == ST_OK,
      out_res.message_count != 8'd0 && out_res.datagram_length != 16'd0,
      "ok response without messages")
   `DVV_ASSERT_NOW(a_stall_needs_rsp, !req_tready, rsp_tvalid,
      "request side stalled with no response waiting")

endmodule

`default_nettype wire
